// ===== rtl/nlxp_pkg.sv =====
// Shared types, character codes and arithmetic helpers of the XYZ word parser.
package nlxp_pkg;

    localparam int FRAC_CNT_W = 3;
    localparam int ACC_W      = 31;
    localparam int SCALE_W    = 20;
    localparam int PROD_W     = ACC_W + SCALE_W;
    localparam int COORD_W    = 32;

    localparam logic [ACC_W-1:0] ACC_SAT = {ACC_W{1'b1}};

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CASE_MASK = 8'hDF;

    localparam logic [1:0] AXIS_NONE = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd1;
    localparam logic [1:0] AXIS_Y    = 2'd2;
    localparam logic [1:0] AXIS_Z    = 2'd3;

    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_XY   = 2'd1;
    localparam logic [1:0] CLASS_Z    = 2'd2;

    // Word commit request handed from the parser to the coordinate stage
    typedef struct packed {
        logic                  valid;
        logic                  eol;
        logic                  commit;
        logic [1:0]            axis;
        logic                  neg;
        logic [ACC_W-1:0]      acc;
        logic [FRAC_CNT_W-1:0] frac;
    } commit_req_t;

    function automatic logic [SCALE_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] k);
        logic [SCALE_W-1:0] r;
        case (k)
            3'd0:    r = SCALE_W'(1);
            3'd1:    r = SCALE_W'(10);
            3'd2:    r = SCALE_W'(100);
            3'd3:    r = SCALE_W'(1000);
            3'd4:    r = SCALE_W'(10000);
            3'd5:    r = SCALE_W'(100000);
            3'd6:    r = SCALE_W'(1000000);
            default: r = SCALE_W'(1);
        endcase
        return r;
    endfunction

    // acc * 10 + d, saturated to the magnitude limit
    function automatic logic [ACC_W-1:0] push_digit(input logic [ACC_W-1:0] acc,
                                                    input logic [3:0] d);
        logic [ACC_W+3:0] v;
        v = ((ACC_W+4)'(acc) << 3) + ((ACC_W+4)'(acc) << 1) + (ACC_W+4)'(d);
        return (v > (ACC_W+4)'(ACC_SAT)) ? ACC_SAT : v[ACC_W-1:0];
    endfunction

endpackage

// ===== rtl/nlxp_if.sv =====
// Valid/ready channel interfaces for the character input and the line result.
interface nlxp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface nlxp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         line_class;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;

    modport source (output valid, output line_class, output x_out, output y_out,
                    output z_out, input ready);
    modport sink   (input valid, input line_class, input x_out, input y_out,
                    input z_out, output ready);
endinterface

// ===== rtl/nlxp_parser.sv =====
// Character input register and word/number parser producing commit requests.
module nlxp_parser
    import nlxp_pkg::*;
#(
    parameter int FRAC_DIGITS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    nlxp_in_if.sink     char_in,
    output commit_req_t req
);

    localparam logic [2:0] PH_SKIP   = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_INT    = 3'd2;
    localparam logic [2:0] PH_FRAC   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [FRAC_CNT_W-1:0] FRAC_MAX = FRAC_CNT_W'(FRAC_DIGITS);

    logic                  in_valid_reg;
    logic [7:0]            ch_reg;
    logic [1:0]            word_axis_reg,     word_axis_next;
    logic                  word_nonempty_reg, word_nonempty_next;
    logic [2:0]            phase_reg,         phase_next;
    logic                  neg_reg,           neg_next;
    logic [ACC_W-1:0]      acc_reg,           acc_next;
    logic [FRAC_CNT_W-1:0] frac_reg,          frac_next;
    commit_req_t           req_reg,           req_next;

    logic       is_nl;
    logic       is_letter;
    logic       is_digit;
    logic       is_space;
    logic [7:0] ch_up;
    logic [1:0] letter_axis;
    logic       commit_now;

    assign char_in.ready = advance;
    assign req           = req_reg;

    always_comb
    begin
        is_nl     = (ch_reg == CH_NL);
        is_letter = ((ch_reg >= CH_UP_A) && (ch_reg <= CH_UP_Z)) ||
                    ((ch_reg >= CH_LO_A) && (ch_reg <= CH_LO_Z));
        is_digit  = (ch_reg >= CH_0) && (ch_reg <= CH_9);
        is_space  = (ch_reg == CH_SPACE) || ((ch_reg >= CH_TAB) && (ch_reg <= CH_CR));
        ch_up     = ch_reg & CASE_MASK;
        if (ch_up == CH_X)
            letter_axis = AXIS_X;
        else if (ch_up == CH_Y)
            letter_axis = AXIS_Y;
        else if (ch_up == CH_Z)
            letter_axis = AXIS_Z;
        else
            letter_axis = AXIS_NONE;
        commit_now = (word_axis_reg != AXIS_NONE) && word_nonempty_reg;

        word_axis_next     = word_axis_reg;
        word_nonempty_next = word_nonempty_reg;
        phase_next         = phase_reg;
        neg_next           = neg_reg;
        acc_next           = acc_reg;
        frac_next          = frac_reg;

        req_next.valid  = 1'b0;
        req_next.eol    = is_nl;
        req_next.commit = commit_now;
        req_next.axis   = word_axis_reg;
        req_next.neg    = neg_reg;
        req_next.acc    = acc_reg;
        req_next.frac   = frac_reg;

        if (in_valid_reg)
        begin
            if (is_nl || is_letter)
            begin
                // close the current word and open the next one
                req_next.valid     = is_nl || commit_now;
                word_axis_next     = is_nl ? AXIS_NONE : letter_axis;
                word_nonempty_next = 1'b0;
                phase_next         = PH_SKIP;
                neg_next           = 1'b0;
                acc_next           = '0;
                frac_next          = '0;
            end
            else if (word_axis_reg != AXIS_NONE)
            begin
                word_nonempty_next = 1'b1;
                case (phase_reg)
                    PH_SKIP:
                    begin
                        if (is_space)
                            phase_next = PH_SKIP;
                        else if ((ch_reg == CH_PLUS) || (ch_reg == CH_MINUS))
                        begin
                            neg_next   = (ch_reg == CH_MINUS);
                            phase_next = PH_SIGNED;
                        end
                        else if (is_digit)
                        begin
                            acc_next   = push_digit(acc_reg, ch_reg[3:0]);
                            phase_next = PH_INT;
                        end
                        else if (ch_reg == CH_POINT)
                            phase_next = PH_FRAC;
                        else
                            phase_next = PH_DONE;
                    end
                    PH_SIGNED, PH_INT:
                    begin
                        if (is_digit)
                        begin
                            acc_next   = push_digit(acc_reg, ch_reg[3:0]);
                            phase_next = PH_INT;
                        end
                        else if (ch_reg == CH_POINT)
                            phase_next = PH_FRAC;
                        else
                            phase_next = PH_DONE;
                    end
                    PH_FRAC:
                    begin
                        if (is_digit)
                        begin
                            // drop fraction digits beyond the scale
                            if (frac_reg < FRAC_MAX)
                            begin
                                acc_next  = push_digit(acc_reg, ch_reg[3:0]);
                                frac_next = frac_reg + 1'b1;
                            end
                        end
                        else
                            phase_next = PH_DONE;
                    end
                    default:
                        phase_next = PH_DONE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            word_axis_reg     <= AXIS_NONE;
            word_nonempty_reg <= 1'b0;
            phase_reg         <= PH_SKIP;
            neg_reg           <= 1'b0;
            acc_reg           <= '0;
            frac_reg          <= '0;
            req_reg           <= '0;
        end
        else if (advance)
        begin
            in_valid_reg      <= char_in.valid;
            word_axis_reg     <= word_axis_next;
            word_nonempty_reg <= word_nonempty_next;
            phase_reg         <= phase_next;
            neg_reg           <= neg_next;
            acc_reg           <= acc_next;
            frac_reg          <= frac_next;
            req_reg           <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            ch_reg <= char_in.ch;
    end

`ifndef SYNTHESIS
    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frac_reg <= FRAC_MAX)
        else $error("fraction digit count exceeds scale");

    a_idle_word_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (word_axis_reg == AXIS_NONE) |-> !word_nonempty_reg)
        else $error("non-axis word marked non-empty");
`endif

endmodule

// ===== rtl/nlxp_commit.sv =====
// Scale multiply, saturation, coordinate registers and line result register.
module nlxp_commit
    import nlxp_pkg::*;
#(
    parameter int FRAC_DIGITS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  commit_req_t req,
    output logic        advance,
    nlxp_out_if.source  line_out
);

    localparam logic [FRAC_CNT_W-1:0] FRAC_MAX = FRAC_CNT_W'(FRAC_DIGITS);
    localparam logic [COORD_W-1:0]    COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic               p_valid_reg;
    logic               p_eol_reg;
    logic               p_commit_reg;
    logic [1:0]         p_axis_reg;
    logic               p_neg_reg;
    logic [PROD_W-1:0]  p_prod_reg;

    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [COORD_W-1:0] z_reg, z_next;
    logic [2:0]         axis_seen_reg, axis_seen_next;
    logic [1:0]         class_reg, class_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_class_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg, out_z_reg;

    logic [SCALE_W-1:0] scale;
    logic [PROD_W-1:0]  prod;
    logic [ACC_W-1:0]   mag;
    logic [COORD_W-1:0] val;
    logic [2:0]         axis_bit;
    logic               take;
    logic               load_out;
    logic [2:0]         seen_mid;
    logic [1:0]         class_mid;

    assign scale = pow10(FRAC_MAX - req.frac);
    assign prod  = PROD_W'(req.acc) * PROD_W'(scale);

    assign advance  = !(p_valid_reg && p_eol_reg && out_valid_reg && !line_out.ready);
    assign load_out = advance && p_valid_reg && p_eol_reg;

    always_comb
    begin
        mag = (p_prod_reg > PROD_W'(ACC_SAT)) ? ACC_SAT : p_prod_reg[ACC_W-1:0];
        val = p_neg_reg ? (COORD_W'(0) - COORD_W'(mag)) : COORD_W'(mag);

        case (p_axis_reg)
            AXIS_X:  axis_bit = 3'b001;
            AXIS_Y:  axis_bit = 3'b010;
            AXIS_Z:  axis_bit = 3'b100;
            default: axis_bit = 3'b000;
        endcase

        // first non-empty word of each axis in a line wins
        take = p_valid_reg && p_commit_reg && (axis_bit != 3'b000) &&
               ((axis_seen_reg & axis_bit) == 3'b000);

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        seen_mid  = axis_seen_reg;
        class_mid = class_reg;
        if (take)
        begin
            case (p_axis_reg)
                AXIS_X:  x_next = val;
                AXIS_Y:  y_next = val;
                AXIS_Z:  z_next = val;
                default: x_next = x_reg;
            endcase
            seen_mid = axis_seen_reg | axis_bit;
            if (class_reg == CLASS_NONE)
                class_mid = (p_axis_reg == AXIS_Z) ? CLASS_Z : CLASS_XY;
        end

        axis_seen_next = load_out ? 3'b000 : seen_mid;
        class_next     = load_out ? CLASS_NONE : class_mid;

        if (load_out)
            out_valid_next = 1'b1;
        else if (line_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            axis_seen_reg <= 3'b000;
            class_reg     <= CLASS_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                p_valid_reg   <= req.valid;
                x_reg         <= x_next;
                y_reg         <= y_next;
                z_reg         <= z_next;
                axis_seen_reg <= axis_seen_next;
                class_reg     <= class_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_eol_reg    <= req.eol;
            p_commit_reg <= req.commit;
            p_axis_reg   <= req.axis;
            p_neg_reg    <= req.neg;
            p_prod_reg   <= prod;
        end
        if (load_out)
        begin
            out_class_reg <= class_mid;
            out_x_reg     <= x_next;
            out_y_reg     <= y_next;
            out_z_reg     <= z_next;
        end
    end

    assign line_out.valid      = out_valid_reg;
    assign line_out.line_class = out_class_reg;
    assign line_out.x_out      = out_x_reg;
    assign line_out.y_out      = out_y_reg;
    assign line_out.z_out      = out_z_reg;

`ifndef SYNTHESIS
    a_class_tracks_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (class_reg == CLASS_NONE) == (axis_seen_reg == 3'b000))
        else $error("line class disagrees with seen axes");

    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (axis_seen_reg == 3'b000) && (class_reg == CLASS_NONE))
        else $error("line state not cleared after end of line");

    a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_class_reg != 2'd3))
        else $error("illegal line class presented");

    a_no_min_coord: assert property (@(posedge clk) disable iff (!rst_n)
        (x_reg != COORD_MIN) && (y_reg != COORD_MIN) && (z_reg != COORD_MIN))
        else $error("coordinate escaped saturation");
`endif

endmodule

// ===== rtl/nc_line_xyz_word_parser_unit.sv =====
// Top level of the line-oriented XYZ word parser.
// The block takes one text byte per cycle on char_in and, for each newline,
// presents one transaction on line_out carrying the line class and the
// current X, Y and Z in units of 10^-FRAC_DIGITS, saturated to +-(2^31-1).
// A byte passes an input register and the parser; a word closed by a letter
// or newline then goes through a scale multiply stage and the coordinate
// stage, and a newline's result is then registered at the output. Input
// is taken every cycle; it holds only when a newline result reaches the
// output register while the previous result there has not been taken.
// No clearing pass is needed after reset.
module nc_line_xyz_word_parser_unit
    import nlxp_pkg::*;
#(
    parameter int FRAC_DIGITS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    nlxp_in_if.sink     char_in,
    nlxp_out_if.source  line_out
);

    logic        advance;
    commit_req_t req;

    nlxp_parser #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .char_in (char_in),
        .req     (req)
    );

    nlxp_commit #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_commit (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .advance  (advance),
        .line_out (line_out)
    );

endmodule
